// File: hw/rtl/gap_buffer_line_editor_defines.svh
// ----------------------------------------------------------------------------
// gap buffer line editor assertion macros
// concurrent assertion helpers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef GAP_BUFFER_LINE_EDITOR_DEFINES_SVH
`define GAP_BUFFER_LINE_EDITOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// File: hw/rtl/gble_pkg.sv
// ----------------------------------------------------------------------------
// gble_pkg
// shared types and key codes of the gap buffer line editor
// ----------------------------------------------------------------------------
package gble_pkg;

  localparam logic [7:0] KEY_DEL     = 8'h7F;
  localparam logic [7:0] KEY_ESC     = 8'h1B;
  localparam logic [7:0] KEY_BRACKET = 8'h5B;
  localparam logic [7:0] KEY_UP      = 8'h41;
  localparam logic [7:0] KEY_DOWN    = 8'h42;
  localparam logic [7:0] KEY_RIGHT   = 8'h43;
  localparam logic [7:0] KEY_LEFT    = 8'h44;
  localparam logic [7:0] PRINT_LO    = 8'h20;
  localparam logic [7:0] PRINT_HI    = 8'h7E;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_UP   = 2'd1;
  localparam logic [1:0] EV_DOWN = 2'd2;

  localparam int Q_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_LEFT   = 3'd3,
    OP_RIGHT  = 3'd4,
    OP_UP     = 3'd5,
    OP_DOWN   = 3'd6
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: hw/rtl/gap_buffer_line_editor.sv
// ----------------------------------------------------------------------------
// gap_buffer_line_editor
// terminal line editor on a gap buffer, redraws the line after every chunk
// ----------------------------------------------------------------------------
// channel  dir  tdata                                       tlast     tuser
// s_axis   in   [1:0] count [9:2] b0 [17:10] b1 [25:18] b2  -         -
// m_axis   out  [7:0] line_char [12:8] cursor_column        is_final  arrow_event
//
// an item reads the line back one character at a time through the registered
// read port of the line store; a move first copies one character across the gap
// up to two chunks queue ahead of the redraw
// rst clears cursor, gap and control; the line store itself is not cleared
// output stalls hold the redraw, a full queue holds s_tready low
// ----------------------------------------------------------------------------
module gap_buffer_line_editor import gble_pkg::*; #(
  parameter int LINE_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // byte_count, first_byte, second_byte, third_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // line_char, cursor_column
  output logic        m_tlast,
  output logic [1:0]  m_tuser   // arrow_event
);

  q_status_t q_status;
  logic      push;
  logic      pop;
  cmd_t      push_cmd;
  cmd_t      head_cmd;

  gble_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_status (q_status),
    .push     (push),
    .cmd      (push_cmd)
  );

  gble_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  gble_back #(
    .LINE_SLOTS (LINE_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (!q_status.empty),
    .q_cmd    (head_cmd),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// File: hw/rtl/gble_front.sv
// ----------------------------------------------------------------------------
// gble_front
// accepts key chunks and classifies them into editor commands
// ----------------------------------------------------------------------------
module gble_front import gble_pkg::*; (
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,
  input  q_status_t   q_status,
  output logic        push,
  output cmd_t        cmd
);

  logic [1:0] byte_count;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [7:0] third_byte;

  assign byte_count  = s_tdata[1:0];
  assign first_byte  = s_tdata[9:2];
  assign second_byte = s_tdata[17:10];
  assign third_byte  = s_tdata[25:18];

  assign s_tready = !q_status.full;
  assign push     = s_tvalid && !q_status.full;

  always_comb begin
    cmd.op = OP_NONE;
    cmd.ch = first_byte;
    if (byte_count == 2'd1) begin
      if (first_byte >= PRINT_LO && first_byte <= PRINT_HI) begin
        cmd.op = OP_INSERT;
      end else if (first_byte == KEY_DEL) begin
        cmd.op = OP_DELETE;
      end
    end else if (byte_count == 2'd3 && first_byte == KEY_ESC &&
                 second_byte == KEY_BRACKET) begin
      unique case (third_byte)
        KEY_UP:    cmd.op = OP_UP;
        KEY_DOWN:  cmd.op = OP_DOWN;
        KEY_RIGHT: cmd.op = OP_RIGHT;
        KEY_LEFT:  cmd.op = OP_LEFT;
        default:   cmd.op = OP_NONE;
      endcase
    end
  end

endmodule

// File: hw/rtl/gble_queue.sv
// ----------------------------------------------------------------------------
// gble_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
`include "gap_buffer_line_editor_defines.svh"

module gble_queue import gble_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head_cmd,
  output q_status_t status
);

  localparam int PW = $clog2(Q_DEPTH);

  cmd_t          slots [Q_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign status.full  = (count == (PW+1)'(Q_DEPTH));
  assign status.empty = (count == '0);
  assign head_cmd     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= (PW+1)'(Q_DEPTH), "queue count overrun")
  `ASSERT_ALWAYS(a_no_overflow, clk, rst, !(push && status.full), "push into full queue")
  `ASSERT_ALWAYS(a_no_underflow, clk, rst, !(pop && status.empty), "pop from empty queue")

endmodule

// File: hw/rtl/gble_back.sv
// ----------------------------------------------------------------------------
// gble_back
// gap buffer store, command execution and serial line redraw
// ----------------------------------------------------------------------------
`include "gap_buffer_line_editor_defines.svh"

module gble_back import gble_pkg::*; #(
  parameter int LINE_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  output logic        m_tlast,
  output logic [1:0]  m_tuser
);

  localparam int AW = $clog2(LINE_SLOTS);
  localparam logic [AW:0]   SLOTS     = (AW+1)'(LINE_SLOTS);
  localparam logic [AW-1:0] LAST_SLOT = AW'(LINE_SLOTS - 1);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_MOVE_RD = 6'b000010,
    S_MOVE_WR = 6'b000100,
    S_RD      = 6'b001000,
    S_OUT     = 6'b010000,
    S_FIN     = 6'b100000
  } state_t;

  state_t        state;
  logic [AW-1:0] cursor;
  logic [AW-1:0] gap_end;
  logic [AW:0]   p;
  logic [AW-1:0] src;
  logic [AW-1:0] dst;
  logic [1:0]    event_code;
  logic [7:0]    rdata;
  logic [7:0]    mem [LINE_SLOTS];

  logic [AW:0]   eff;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [4:0]    col;

  // skip over the gap once the left part is done
  assign eff = (p == {1'b0, cursor}) ? ({1'b0, gap_end} + (AW+1)'(1)) : p;

  assign q_pop   = (state == S_IDLE) && q_valid;
  assign rd_en   = (state == S_MOVE_RD) || ((state == S_RD) && (eff != SLOTS));
  assign rd_addr = (state == S_MOVE_RD) ? src : eff[AW-1:0];
  assign wr_en   = ((state == S_IDLE) && q_valid && (q_cmd.op == OP_INSERT) &&
                    (cursor < gap_end)) || (state == S_MOVE_WR);
  assign wr_addr = (state == S_MOVE_WR) ? dst : cursor;
  assign wr_data = (state == S_MOVE_WR) ? rdata : q_cmd.ch;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cursor     <= '0;
      gap_end    <= LAST_SLOT;
      p          <= '0;
      event_code <= EV_NONE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            event_code <= EV_NONE;
            p          <= '0;
            state      <= S_RD;
            unique case (q_cmd.op)
              OP_INSERT: begin
                if (cursor < gap_end) begin
                  cursor <= cursor + AW'(1);
                end
              end
              OP_DELETE: begin
                if (cursor != '0) begin
                  cursor <= cursor - AW'(1);
                end
              end
              OP_LEFT: begin
                if (cursor != '0) begin
                  src     <= cursor - AW'(1);
                  dst     <= gap_end;
                  cursor  <= cursor - AW'(1);
                  gap_end <= gap_end - AW'(1);
                  state   <= S_MOVE_RD;
                end
              end
              OP_RIGHT: begin
                if (gap_end != LAST_SLOT) begin
                  src     <= gap_end + AW'(1);
                  dst     <= cursor;
                  cursor  <= cursor + AW'(1);
                  gap_end <= gap_end + AW'(1);
                  state   <= S_MOVE_RD;
                end
              end
              OP_UP:   event_code <= EV_UP;
              OP_DOWN: event_code <= EV_DOWN;
              default: ;
            endcase
          end
        end
        S_MOVE_RD: state <= S_MOVE_WR;
        S_MOVE_WR: state <= S_RD;
        S_RD: begin
          if (eff == SLOTS) begin
            state <= S_FIN;
          end else begin
            p     <= eff + (AW+1)'(1);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            state <= S_RD;
          end
        end
        S_FIN: begin
          if (m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign col      = 5'(cursor);
  assign m_tvalid = (state == S_OUT) || (state == S_FIN);
  assign m_tlast  = (state == S_FIN);
  assign m_tuser  = (state == S_FIN) ? event_code : EV_NONE;
  assign m_tdata  = (state == S_FIN) ? {3'b000, col, 8'h00} : {3'b000, 5'b00000, rdata};

  `ASSERT_ALWAYS(a_gap_order, clk, rst, cursor <= gap_end, "cursor beyond gap end")
  `ASSERT_NEXT(a_final_done, clk, rst, (state == S_FIN) && m_tready, state == S_IDLE, "final beat not closing run")
  `ASSERT_NEXT(a_hold_line, clk, rst, state == S_OUT, $stable(cursor) && $stable(gap_end), "line moved during redraw")

endmodule
